// ===== design/ubxfr_pkg.sv =====
package ubxfr_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned IDX_W  = 2;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd181;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd98;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 16'd1016;

  typedef enum logic [IDX_W-1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_MAX_PAYLOAD = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    PH_HUNT1   = 4'd0,
    PH_HUNT2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK_A    = 4'd7,
    PH_CK_B    = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2,
    KIND_LONG = 2'd3
  } kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_first;
    logic [BYTE_W-1:0] sync_second;
    logic [LEN_W-1:0]  max_payload;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] msg_class;
    logic [BYTE_W-1:0] msg_id;
    logic [LEN_W-1:0]  offset;
    logic [LEN_W-1:0]  frame_length;
  } res_t;

endpackage

// ===== design/ubx_frame_receiver_unit.sv =====
// An accepted byte is held in the input register and its result is loaded into the
// output register; it is held back while a waiting result is stalled at the output.
// Throughput: one byte per cycle while the output is not stalled; the parser step and byte sums are combinational.
// An input register and an output register part the two channels.
// Reset (rst, synchronous): drops all items in flight, returns to the sync hunt
// and restores the sync bytes and payload limit to their defaults.
module ubx_frame_receiver_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ubxfr_pkg::BYTE_W-1:0]  rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    kind,
  output logic [ubxfr_pkg::BYTE_W-1:0]  data_byte,
  output logic [ubxfr_pkg::BYTE_W-1:0]  msg_class,
  output logic [ubxfr_pkg::BYTE_W-1:0]  msg_id,
  output logic [ubxfr_pkg::LEN_W-1:0]   offset,
  output logic [ubxfr_pkg::LEN_W-1:0]   frame_length,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ubxfr_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ubxfr_pkg::LEN_W-1:0]   cfg_data
);

  ubxfr_pkg::cfg_t               cfg;
  ubxfr_pkg::res_t               res;
  ubxfr_pkg::res_t               out_res;
  logic                          res_valid;
  logic                          s1_valid;
  logic [ubxfr_pkg::BYTE_W-1:0]  s1_byte;
  logic                          advance;
  logic                          accept;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  ubxfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ubxfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .rx_byte   (s1_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // hold the accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= rx_byte;
    end
  end

  // load the result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign kind         = out_res.kind;
  assign data_byte    = out_res.data_byte;
  assign msg_class    = out_res.msg_class;
  assign msg_id       = out_res.msg_id;
  assign offset       = out_res.offset;
  assign frame_length = out_res.frame_length;

endmodule

// ===== design/ubxfr_cfg_regs.sv =====
module ubxfr_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ubxfr_pkg::IDX_W-1:0]     cfg_index,
  input  logic [ubxfr_pkg::LEN_W-1:0]     cfg_data,
  output ubxfr_pkg::cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first  <= ubxfr_pkg::SYNC_FIRST_RST;
      cfg.sync_second <= ubxfr_pkg::SYNC_SECOND_RST;
      cfg.max_payload <= ubxfr_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (ubxfr_pkg::reg_idx_t'(cfg_index))
        ubxfr_pkg::REG_SYNC_FIRST:  cfg.sync_first  <= cfg_data[ubxfr_pkg::BYTE_W-1:0];
        ubxfr_pkg::REG_SYNC_SECOND: cfg.sync_second <= cfg_data[ubxfr_pkg::BYTE_W-1:0];
        ubxfr_pkg::REG_MAX_PAYLOAD: cfg.max_payload <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/ubxfr_parser.sv =====
module ubxfr_parser (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic [ubxfr_pkg::BYTE_W-1:0]     rx_byte,
  input  ubxfr_pkg::cfg_t                  cfg,
  output logic                             res_valid,
  output ubxfr_pkg::res_t                  res
);

  ubxfr_pkg::phase_t                phase, phase_next;
  logic [ubxfr_pkg::BYTE_W-1:0]     class_hold, class_hold_next;
  logic [ubxfr_pkg::BYTE_W-1:0]     id_hold, id_hold_next;
  logic [ubxfr_pkg::LEN_W-1:0]      length_hold, length_hold_next;
  logic [ubxfr_pkg::LEN_W-1:0]      byte_count, byte_count_next;
  logic [ubxfr_pkg::BYTE_W-1:0]     sum_a, sum_a_next;
  logic [ubxfr_pkg::BYTE_W-1:0]     sum_b, sum_b_next;
  logic                             first_check_ok, first_check_ok_next;
  logic [ubxfr_pkg::BYTE_W-1:0]     add_a;
  logic [ubxfr_pkg::BYTE_W-1:0]     full_len_lo;
  logic [ubxfr_pkg::LEN_W-1:0]      full_len;
  logic [ubxfr_pkg::LEN_W-1:0]      count_inc;
  logic                             too_long;

  assign add_a       = sum_a + rx_byte;
  assign full_len_lo = length_hold[ubxfr_pkg::BYTE_W-1:0];
  assign full_len    = {rx_byte, full_len_lo};
  assign too_long    = full_len > cfg.max_payload;
  assign count_inc   = byte_count + 16'd1;

  // next state
  always_comb begin
    phase_next          = phase;
    class_hold_next     = class_hold;
    id_hold_next        = id_hold;
    length_hold_next    = length_hold;
    byte_count_next     = byte_count;
    sum_a_next          = sum_a;
    sum_b_next          = sum_b;
    first_check_ok_next = first_check_ok;
    case (phase)
      ubxfr_pkg::PH_HUNT2: begin
        if (rx_byte == cfg.sync_second) begin
          phase_next = ubxfr_pkg::PH_CLASS;
        end else if (rx_byte == cfg.sync_first) begin
          phase_next = ubxfr_pkg::PH_HUNT2;
        end else begin
          phase_next = ubxfr_pkg::PH_HUNT1;
        end
      end
      ubxfr_pkg::PH_CLASS: begin
        class_hold_next = rx_byte;
        sum_a_next      = rx_byte;
        sum_b_next      = rx_byte;
        phase_next      = ubxfr_pkg::PH_ID;
      end
      ubxfr_pkg::PH_ID: begin
        id_hold_next = rx_byte;
        sum_a_next   = add_a;
        sum_b_next   = sum_b + add_a;
        phase_next   = ubxfr_pkg::PH_LEN_LO;
      end
      ubxfr_pkg::PH_LEN_LO: begin
        length_hold_next = {8'd0, rx_byte};
        sum_a_next       = add_a;
        sum_b_next       = sum_b + add_a;
        phase_next       = ubxfr_pkg::PH_LEN_HI;
      end
      ubxfr_pkg::PH_LEN_HI: begin
        length_hold_next = full_len;
        sum_a_next       = add_a;
        sum_b_next       = sum_b + add_a;
        byte_count_next  = '0;
        if (too_long) begin
          phase_next = ubxfr_pkg::PH_HUNT1;
        end else if (full_len == '0) begin
          phase_next = ubxfr_pkg::PH_CK_A;
        end else begin
          phase_next = ubxfr_pkg::PH_PAYLOAD;
        end
      end
      ubxfr_pkg::PH_PAYLOAD: begin
        sum_a_next      = add_a;
        sum_b_next      = sum_b + add_a;
        byte_count_next = count_inc;
        if (count_inc >= length_hold) begin
          phase_next = ubxfr_pkg::PH_CK_A;
        end
      end
      ubxfr_pkg::PH_CK_A: begin
        first_check_ok_next = (rx_byte == sum_a);
        phase_next          = ubxfr_pkg::PH_CK_B;
      end
      ubxfr_pkg::PH_CK_B: begin
        phase_next = ubxfr_pkg::PH_HUNT1;
      end
      default: begin
        phase_next = (rx_byte == cfg.sync_first) ? ubxfr_pkg::PH_HUNT2 : ubxfr_pkg::PH_HUNT1;
      end
    endcase
  end

  // outputs
  always_comb begin
    res_valid        = 1'b0;
    res.kind         = ubxfr_pkg::KIND_DATA;
    res.data_byte    = '0;
    res.msg_class    = class_hold;
    res.msg_id       = id_hold;
    res.offset       = '0;
    res.frame_length = length_hold;
    case (phase)
      ubxfr_pkg::PH_LEN_HI: begin
        res_valid        = too_long;
        res.kind         = ubxfr_pkg::KIND_LONG;
        res.frame_length = full_len;
      end
      ubxfr_pkg::PH_PAYLOAD: begin
        res_valid     = 1'b1;
        res.data_byte = rx_byte;
        res.offset    = byte_count;
      end
      ubxfr_pkg::PH_CK_B: begin
        res_valid = 1'b1;
        res.kind  = (first_check_ok && rx_byte == sum_b) ? ubxfr_pkg::KIND_GOOD
                                                         : ubxfr_pkg::KIND_BAD;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= ubxfr_pkg::PH_HUNT1;
      class_hold     <= '0;
      id_hold        <= '0;
      length_hold    <= '0;
      byte_count     <= '0;
      sum_a          <= '0;
      sum_b          <= '0;
      first_check_ok <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      class_hold     <= class_hold_next;
      id_hold        <= id_hold_next;
      length_hold    <= length_hold_next;
      byte_count     <= byte_count_next;
      sum_a          <= sum_a_next;
      sum_b          <= sum_b_next;
      first_check_ok <= first_check_ok_next;
    end
  end

endmodule

// ===== design/ubxfr_checker.sv =====
module ubxfr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    kind,
  input logic [ubxfr_pkg::BYTE_W-1:0]  data_byte,
  input logic [ubxfr_pkg::LEN_W-1:0]   offset,
  input logic [ubxfr_pkg::LEN_W-1:0]   frame_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(offset)
      && $stable(data_byte))
    else $error("stalled output item changed");

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output item present after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output is free");

  a_frame_end_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != ubxfr_pkg::KIND_DATA |-> data_byte == '0 && offset == '0)
    else $error("frame end item carries payload data");

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == ubxfr_pkg::KIND_DATA |-> offset < frame_length)
    else $error("payload offset beyond frame length");

endmodule

bind ubx_frame_receiver_unit ubxfr_checker u_ubxfr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .kind         (kind),
  .data_byte    (data_byte),
  .offset       (offset),
  .frame_length (frame_length)
);

// ===== dv/ubx_frame_tracker_pkg.sv =====
package ubx_frame_tracker_pkg;
  import ubxfr_pkg::*;

  class frame_tracker;
    logic [BYTE_W-1:0] want_sync1;
    logic [BYTE_W-1:0] want_sync2;
    logic [LEN_W-1:0]  len_limit;

    phase_t            hunt_phase;
    logic [BYTE_W-1:0] cur_class;
    logic [BYTE_W-1:0] cur_id;
    logic [LEN_W-1:0]  cur_len;
    logic [LEN_W-1:0]  pay_count;
    logic [BYTE_W-1:0] fl_a;
    logic [BYTE_W-1:0] fl_b;
    logic              ck_a_ok;

    res_t              due_results[$];
    int unsigned       mismatches;

    function new();
      want_sync1 = SYNC_FIRST_RST;
      want_sync2 = SYNC_SECOND_RST;
      len_limit  = MAX_PAYLOAD_RST;
      hunt_phase = PH_HUNT1;
      cur_class  = '0;
      cur_id     = '0;
      cur_len    = '0;
      pay_count  = '0;
      fl_a       = '0;
      fl_b       = '0;
      ck_a_ok    = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [LEN_W-1:0] val);
      case (idx)
        REG_SYNC_FIRST:  want_sync1 = val[BYTE_W-1:0];
        REG_SYNC_SECOND: want_sync2 = val[BYTE_W-1:0];
        REG_MAX_PAYLOAD: len_limit  = val;
        default: ;
      endcase
    endfunction

    function void fold(logic [BYTE_W-1:0] v);
      fl_a = fl_a + v;
      fl_b = fl_b + fl_a;
    endfunction

    function void emit(kind_t k, logic [BYTE_W-1:0] d, logic [LEN_W-1:0] off);
      res_t r;
      r.kind         = k;
      r.data_byte    = d;
      r.msg_class    = cur_class;
      r.msg_id       = cur_id;
      r.offset       = off;
      r.frame_length = cur_len;
      due_results.push_back(r);
    endfunction

    function void take_byte(logic [BYTE_W-1:0] v);
      case (hunt_phase)
        PH_HUNT2: begin
          if (v == want_sync2) hunt_phase = PH_CLASS;
          else if (v == want_sync1) hunt_phase = PH_HUNT2;
          else hunt_phase = PH_HUNT1;
        end
        PH_CLASS: begin
          cur_class = v;
          fl_a = '0;
          fl_b = '0;
          fold(v);
          hunt_phase = PH_ID;
        end
        PH_ID: begin
          cur_id = v;
          fold(v);
          hunt_phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          cur_len = {8'h00, v};
          fold(v);
          hunt_phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          cur_len[LEN_W-1:BYTE_W] = v;
          fold(v);
          pay_count = '0;
          if (cur_len > len_limit) begin
            emit(KIND_LONG, '0, '0);
            hunt_phase = PH_HUNT1;
          end else if (cur_len == '0) begin
            hunt_phase = PH_CK_A;
          end else begin
            hunt_phase = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          fold(v);
          emit(KIND_DATA, v, pay_count);
          pay_count = pay_count + 16'd1;
          if (pay_count >= cur_len) hunt_phase = PH_CK_A;
        end
        PH_CK_A: begin
          ck_a_ok = (v == fl_a);
          hunt_phase = PH_CK_B;
        end
        PH_CK_B: begin
          if (ck_a_ok && v == fl_b) emit(KIND_GOOD, '0, '0);
          else emit(KIND_BAD, '0, '0);
          hunt_phase = PH_HUNT1;
        end
        default: begin
          if (v == want_sync1) hunt_phase = PH_HUNT2;
          else hunt_phase = PH_HUNT1;
        end
      endcase
    endfunction

    function void match_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d data=%02h class=%02h id=%02h off=%0d len=%0d",
                   got.kind, got.data_byte, got.msg_class, got.msg_id, got.offset,
                   got.frame_length);
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
          got.msg_class !== want.msg_class || got.msg_id !== want.msg_id ||
          got.offset !== want.offset || got.frame_length !== want.frame_length) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch");
          $display("  expected kind=%0d data=%02h class=%02h id=%02h off=%0d len=%0d",
                   want.kind, want.data_byte, want.msg_class, want.msg_id, want.offset,
                   want.frame_length);
          $display("  actual   kind=%0d data=%02h class=%02h id=%02h off=%0d len=%0d",
                   got.kind, got.data_byte, got.msg_class, got.msg_id, got.offset,
                   got.frame_length);
        end
      end
    endfunction

    function int unsigned outstanding();
      return due_results.size();
    endfunction
  endclass

endpackage

// ===== dv/ubx_frame_receiver_unit_test.sv =====
module ubx_frame_receiver_unit_test;
  import ubxfr_pkg::*;
  import ubx_frame_tracker_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE   = 2'd3;
  localparam int unsigned      STALL_LIMIT = 4000;
  localparam int unsigned      TAIL_WAIT   = 8;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        kind;
  logic [BYTE_W-1:0] data_byte;
  logic [BYTE_W-1:0] msg_class;
  logic [BYTE_W-1:0] msg_id;
  logic [LEN_W-1:0]  offset;
  logic [LEN_W-1:0]  frame_length;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [LEN_W-1:0]  cfg_data = '0;

  frame_tracker sb;
  bit           calm_in = 1'b0;
  bit           calm_out = 1'b0;
  int unsigned  sent_count = 0;
  int unsigned  idle_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ubx_frame_receiver_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .data_byte    (data_byte),
    .msg_class    (msg_class),
    .msg_id       (msg_id),
    .offset       (offset),
    .frame_length (frame_length),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("ubx_frame_receiver_unit verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned hold;
    res_t        got;
    wait (!rst);
    forever begin
      hold = calm_out ? 0 : $urandom_range(0, 12);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      got.kind         = kind_t'(kind);
      got.data_byte    = data_byte;
      got.msg_class    = msg_class;
      got.msg_id       = msg_id;
      got.offset       = offset;
      got.frame_length = frame_length;
      sb.match_result(got);
    end
  end

  task automatic put_byte(input logic [BYTE_W-1:0] v);
    int unsigned gap;
    gap = calm_in ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= v;
    // hold the item until the block takes it
    do @(posedge clk); while (in_stall);
    sb.take_byte(v);
    sent_count++;
  endtask

  task automatic put_summed(input logic [BYTE_W-1:0] v, inout logic [BYTE_W-1:0] sa,
                            inout logic [BYTE_W-1:0] sc);
    sa = sa + v;
    sc = sc + sa;
    put_byte(v);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic apply_config(input logic [BYTE_W-1:0] s1, input logic [BYTE_W-1:0] s2,
                              input logic [LEN_W-1:0] lim);
    logic [LEN_W-1:0] w;
    w = LEN_W'($urandom);
    w[BYTE_W-1:0] = s1;
    write_reg(REG_SYNC_FIRST, w);
    w = LEN_W'($urandom);
    w[BYTE_W-1:0] = s2;
    write_reg(REG_SYNC_SECOND, w);
    write_reg(REG_MAX_PAYLOAD, lim);
    w = LEN_W'($urandom);
    write_reg(REG_SPARE, w);
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] cls, input logic [BYTE_W-1:0] id,
                            input logic [LEN_W-1:0] len, input bit spoil);
    logic [BYTE_W-1:0] sa;
    logic [BYTE_W-1:0] sc;
    sa = '0;
    sc = '0;
    put_byte(sb.want_sync1);
    put_byte(sb.want_sync2);
    put_summed(cls, sa, sc);
    put_summed(id, sa, sc);
    put_summed(len[BYTE_W-1:0], sa, sc);
    put_summed(len[LEN_W-1:BYTE_W], sa, sc);
    if (sb.hunt_phase == PH_HUNT1) return;
    for (int unsigned i = 0; i < 32'(len); i++) put_summed(BYTE_W'($urandom), sa, sc);
    if (spoil) begin
      if ($urandom_range(0, 1) == 0) sa[3'($urandom_range(0, 7))] ^= 1'b1;
      else sc[3'($urandom_range(0, 7))] ^= 1'b1;
    end
    put_byte(sa);
    put_byte(sc);
  endtask

  task automatic settle();
    logic [BYTE_W-1:0] v;
    while (sb.hunt_phase != PH_HUNT1) begin
      if (sb.hunt_phase == PH_LEN_LO) begin
        v = BYTE_W'($urandom_range(0, 8));
      end else if (sb.hunt_phase == PH_LEN_HI) begin
        v = 8'h00;
      end else begin
        v = BYTE_W'($urandom);
        while (v == sb.want_sync1 || v == sb.want_sync2) v = BYTE_W'($urandom);
      end
      put_byte(v);
    end
  endtask

  function automatic logic [LEN_W-1:0] pick_len();
    int unsigned lim;
    int unsigned r;
    lim = 32'(sb.len_limit);
    r = $urandom_range(0, 99);
    if (r < 3) return (lim <= 320) ? LEN_W'(lim) : LEN_W'($urandom_range(256, 320));
    if (r < 8 && lim <= 320) return LEN_W'(lim);
    return LEN_W'($urandom_range(0, (lim < 12) ? lim : 12));
  endfunction

  task automatic random_traffic(input int unsigned n);
    int unsigned stop;
    int unsigned pick;
    int unsigned lim;
    int unsigned burst;
    stop = sent_count + n;
    while (sent_count < stop) begin
      settle();
      calm_in  = ($urandom_range(0, 6) == 0);
      calm_out = ($urandom_range(0, 6) == 0);
      lim  = 32'(sb.len_limit);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(BYTE_W'($urandom), BYTE_W'($urandom), pick_len(),
                   $urandom_range(0, 5) == 0);
      end else if (pick < 80 && lim < 65535) begin
        if ($urandom_range(0, 2) == 0) begin
          send_frame(BYTE_W'($urandom), BYTE_W'($urandom), LEN_W'(lim + 1), 1'b0);
        end else begin
          send_frame(BYTE_W'($urandom), BYTE_W'($urandom),
                     LEN_W'($urandom_range(lim + 1, 65535)), 1'b0);
        end
      end else if (pick < 87) begin
        put_byte(sb.want_sync1);
        put_byte(BYTE_W'($urandom));
      end else if (pick < 93) begin
        put_byte(sb.want_sync1);
        put_byte(sb.want_sync2);
        burst = $urandom_range(1, 3);
        repeat (burst) put_byte(BYTE_W'($urandom));
      end else if (pick < 98) begin
        burst = $urandom_range(1, 4);
        repeat (burst) put_byte(BYTE_W'($urandom));
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    put_byte(SYNC_FIRST_RST);
    put_byte(8'h00);
    put_byte(SYNC_FIRST_RST);
    send_frame(8'hFF, 8'h00, 16'd0, 1'b0);
    send_frame(8'h00, 8'hFF, 16'd1, 1'b1);
    send_frame(8'hA5, 8'h5A, 16'hFFFF, 1'b0);

    random_traffic(240);
    apply_config(8'h00, 8'hFF, 16'd0);
    random_traffic(240);
    apply_config(8'hFF, 8'h00, 16'hFFFF);
    random_traffic(240);
    apply_config(8'h55, 8'h55, 16'd16);
    random_traffic(240);
    apply_config(BYTE_W'($urandom), BYTE_W'($urandom), LEN_W'($urandom_range(1, 40)));
    random_traffic(240);
    apply_config(SYNC_FIRST_RST, SYNC_SECOND_RST, MAX_PAYLOAD_RST);
    random_traffic(240);

    drain();
    if (sb.mismatches == 0) begin
      $display("ubx_frame_receiver_unit verification clean");
    end else begin
      $display("ubx_frame_receiver_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== ubx_frame_receiver_unit.f =====
design/ubxfr_pkg.sv
design/ubxfr_cfg_regs.sv
design/ubxfr_parser.sv
design/ubx_frame_receiver_unit.sv
design/ubxfr_checker.sv
dv/ubx_frame_tracker_pkg.sv
dv/ubx_frame_receiver_unit_test.sv
